// ===== hdl/gpua_pkg.sv =====
// Shared types, codes and constants for the growing pool unit allocator.
package gpua_pkg;

  // Default number of units in the pool.
  localparam int GPUA_CAPACITY = 1024;

  // Fixed field widths of the request and response items.
  localparam int GPUA_HANDLE_W = 10;
  localparam int GPUA_COUNT_W  = 11;
  localparam int GPUA_CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [GPUA_COUNT_W-1:0] GPUA_INIT_UNITS_RST = GPUA_COUNT_W'(16);
  localparam logic                    GPUA_GEOMETRIC_RST  = 1'b0;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_LET = 1'b1
  } gpua_action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } gpua_status_t;

  typedef enum logic [GPUA_CFG_IDX_W-1:0] {
    CFG_INITIAL_UNITS = 2'd0,
    CFG_GEOMETRIC     = 2'd1
  } gpua_cfg_idx_t;

  typedef struct packed {
    gpua_action_t              action;
    logic [GPUA_HANDLE_W-1:0]  unit_handle;
  } gpua_in_t;

  typedef struct packed {
    gpua_status_t              status;
    logic [GPUA_HANDLE_W-1:0]  granted_handle;
    logic [GPUA_COUNT_W-1:0]   units_in_use;
  } gpua_out_t;

  // Free list commands issued by the pool logic.
  typedef struct packed {
    logic pop;
    logic push;
  } gpua_fl_ctrl_t;

endpackage

// ===== hdl/growing_pool_unit_allocator.sv =====
// Top level of the growing pool unit allocator.
//
// Usage: each request on the in channel (in_valid, in_stall, in_data) is
// either a get, which hands out a unit handle, or a let, which returns one.
// Every request yields exactly one response on the out channel (out_valid,
// out_stall, out_data) with a status, the granted handle and the count of
// units in use. A transfer happens on a rising edge with valid high and
// stall low.
// A request passes through the input register and then the output register,
// where out_valid rises; the response transfers once out_stall is low.
// Throughput is one request per cycle while the receiver does not stall.
// That rate is set by the link memory: on each pop that leaves a unit on
// the list, its single read port prefetches the successor of the new head,
// so back-to-back pops never wait on a memory read.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no request is outstanding.
// Reset (rst, synchronous) empties the free list, closes all blocks, zeroes
// the in-use count and restores the registers. The link memory needs no
// clearing pass; its entries are only read after a let has written them.
// When the receiver stalls, the response holds; one more request may still
// transfer into the input register, after which in_stall goes high.
module growing_pool_unit_allocator #(
  parameter int CAPACITY = gpua_pkg::GPUA_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  gpua_pkg::gpua_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output gpua_pkg::gpua_out_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gpua_pkg::GPUA_CFG_IDX_W-1:0]   cfg_index,
  input  logic [gpua_pkg::GPUA_COUNT_W-1:0]     cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = $clog2(CAPACITY);

  // Input stage register holding the request being worked on.
  logic               in_vq;
  gpua_pkg::gpua_in_t in_q;

  // The output stage can take a new response when empty or being drained;
  // the request in the input stage is processed exactly on that cycle.
  logic advance;
  logic fire;

  // Configuration registers.
  logic [gpua_pkg::GPUA_COUNT_W-1:0] initial_units;
  logic                              geometric_growth;

  gpua_pkg::gpua_fl_ctrl_t fl_ctrl;
  logic [HW-1:0]           fl_handle;
  logic [CW-1:0]           fl_head;
  gpua_pkg::gpua_out_t     result;

  assign advance  = !out_valid || !out_stall;
  assign fire     = in_vq && advance;
  assign in_stall = in_vq && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vq <= 1'b0;
    end else if (!in_stall) begin
      in_vq <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vq;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  // Register writes are accepted every cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_units    <= gpua_pkg::GPUA_INIT_UNITS_RST;
      geometric_growth <= gpua_pkg::GPUA_GEOMETRIC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpua_pkg::CFG_INITIAL_UNITS: initial_units    <= cfg_data;
        gpua_pkg::CFG_GEOMETRIC:     geometric_growth <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gpua_pool #(
    .CAPACITY(CAPACITY)
  ) u_pool (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .req              (in_q),
    .initial_units    (initial_units),
    .geometric_growth (geometric_growth),
    .fl_head          (fl_head),
    .fl_ctrl          (fl_ctrl),
    .fl_handle        (fl_handle),
    .result           (result)
  );

  gpua_free_list #(
    .CAPACITY(CAPACITY)
  ) u_free_list (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (fl_ctrl),
    .push_handle (fl_handle),
    .head        (fl_head)
  );

endmodule

// ===== hdl/gpua_free_list.sv =====
// LIFO free list: link memory plus head and prefetched successor registers.
module gpua_free_list #(
  parameter int CAPACITY = gpua_pkg::GPUA_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gpua_pkg::gpua_fl_ctrl_t            ctrl,
  input  logic [$clog2(CAPACITY)-1:0]        push_handle,
  output logic [$clog2(CAPACITY+1)-1:0]      head
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = $clog2(CAPACITY);
  localparam logic [CW-1:0] NULL_MARK = CW'(CAPACITY);

  logic [CW-1:0] link_mem [CAPACITY];
  logic [CW-1:0] rd_q;
  logic [CW-1:0] second_r;
  logic          sel_mem;
  logic [CW-1:0] second_eff;
  logic          rd_en;
  logic [HW-1:0] rd_addr;

  // The successor of the head sits either in a register (after a push) or in
  // the memory read register (after a pop prefetched it).
  assign second_eff = sel_mem ? rd_q : second_r;
  assign rd_en      = ctrl.pop && (second_eff != NULL_MARK);
  assign rd_addr    = second_eff[HW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      link_mem[push_handle] <= head;
    end
    if (rd_en) begin
      rd_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= NULL_MARK;
      second_r <= NULL_MARK;
      sel_mem  <= 1'b0;
    end else if (ctrl.pop) begin
      head     <= second_eff;
      second_r <= NULL_MARK;
      sel_mem  <= (second_eff != NULL_MARK);
    end else if (ctrl.push) begin
      head     <= CW'(push_handle);
      second_r <= head;
      sel_mem  <= 1'b0;
    end
  end

endmodule

// ===== hdl/gpua_pool.sv =====
// Request decision, block growth and in-use counting for the allocator.
module gpua_pool #(
  parameter int CAPACITY = gpua_pkg::GPUA_CAPACITY
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    fire,
  input  gpua_pkg::gpua_in_t                      req,
  input  logic [gpua_pkg::GPUA_COUNT_W-1:0]       initial_units,
  input  logic                                    geometric_growth,
  input  logic [$clog2(CAPACITY+1)-1:0]           fl_head,
  output gpua_pkg::gpua_fl_ctrl_t                 fl_ctrl,
  output logic [$clog2(CAPACITY)-1:0]             fl_handle,
  output gpua_pkg::gpua_out_t                     result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = $clog2(CAPACITY);
  localparam int SW = ((CW > gpua_pkg::GPUA_COUNT_W) ? CW : gpua_pkg::GPUA_COUNT_W) + 2;
  localparam logic [CW-1:0] NULL_MARK = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_CW    = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_SW    = SW'(CAPACITY);

  logic [CW-1:0] fresh_next, fresh_next_next;
  logic [CW-1:0] block_end, block_end_next;
  logic [CW-1:0] last_size, last_size_next;
  logic [CW-1:0] prior_size, prior_size_next;
  logic [CW-1:0] in_use, in_use_next;

  logic [SW-1:0] last_w, prior_w, diff, size, end_sum;
  logic          is_get, head_ok, fresh_ok, fits, let_ok;
  logic [HW-1:0] grant;
  gpua_pkg::gpua_status_t status;

  // Size of the block that would be opened next.
  always_comb begin
    last_w  = SW'(last_size);
    prior_w = SW'(prior_size);
    diff    = (last_w >= prior_w) ? (last_w - prior_w) : (prior_w - last_w);
    if (last_size == '0) begin
      size = (initial_units == '0) ? SW'(1) : SW'(initial_units);
    end else if (geometric_growth || (diff == '0)) begin
      size = last_w << 1;
    end else begin
      size = last_w + diff;
    end
    end_sum = SW'(block_end) + size;
    fits    = (end_sum <= CAP_SW);
  end

  assign is_get    = (req.action == gpua_pkg::ACT_GET);
  assign head_ok   = (fl_head != NULL_MARK);
  assign fresh_ok  = (fresh_next < block_end);
  assign let_ok    = (SW'(req.unit_handle) < SW'(fresh_next));
  assign fl_handle = HW'(req.unit_handle);

  always_comb begin
    fresh_next_next = fresh_next;
    block_end_next  = block_end;
    last_size_next  = last_size;
    prior_size_next = prior_size;
    in_use_next     = in_use;
    grant           = '0;
    status          = gpua_pkg::ST_OK;
    fl_ctrl.pop     = 1'b0;
    fl_ctrl.push    = 1'b0;
    if (is_get) begin
      if (head_ok) begin
        grant       = fl_head[HW-1:0];
        fl_ctrl.pop = fire;
      end else if (fresh_ok) begin
        grant           = fresh_next[HW-1:0];
        fresh_next_next = fresh_next + CW'(1);
      end else if (fits) begin
        grant           = block_end[HW-1:0];
        prior_size_next = (last_size == '0) ? CW'(size) : last_size;
        last_size_next  = CW'(size);
        fresh_next_next = block_end + CW'(1);
        block_end_next  = CW'(end_sum);
      end else begin
        status = gpua_pkg::ST_EXHAUSTED;
      end
      if ((status == gpua_pkg::ST_OK) && (in_use != CAP_CW)) begin
        in_use_next = in_use + CW'(1);
      end
    end else begin
      if (let_ok) begin
        fl_ctrl.push = fire;
        if (in_use != '0) begin
          in_use_next = in_use - CW'(1);
        end
      end else begin
        status = gpua_pkg::ST_BAD_HANDLE;
      end
    end
    result.status         = status;
    result.granted_handle = gpua_pkg::GPUA_HANDLE_W'(grant);
    result.units_in_use   = gpua_pkg::GPUA_COUNT_W'(in_use_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_next <= '0;
      block_end  <= '0;
      last_size  <= '0;
      prior_size <= '0;
      in_use     <= '0;
    end else if (fire) begin
      fresh_next <= fresh_next_next;
      block_end  <= block_end_next;
      last_size  <= last_size_next;
      prior_size <= prior_size_next;
      in_use     <= in_use_next;
    end
  end

endmodule

// ===== hdl/gpua_checker.sv =====
// Port-level checker for the growing pool unit allocator, with its bind.
module gpua_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input gpua_pkg::gpua_out_t                   out_data
);

  // Count reported by the most recently transferred response.
  logic [gpua_pkg::GPUA_COUNT_W-1:0] prev_count;
  logic                              prev_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_seen <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      prev_count <= out_data.units_in_use;
    end
  end

  // A stalled response holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // A failed request hands out no unit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != gpua_pkg::ST_OK) |-> out_data.granted_handle == '0)
    else $error("handle granted on a failed request");

  // A failed request leaves the in-use count unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && prev_seen && (out_data.status != gpua_pkg::ST_OK)
      |-> out_data.units_in_use == prev_count)
    else $error("in-use count moved on a failed request");

  // Requests are only held back while a response waits on the receiver.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

endmodule

bind growing_pool_unit_allocator gpua_checker u_gpua_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the growing pool unit allocator.
module tb_top;

  // Pool size and the marker that ends the free list in the predictor.
  localparam int POOL_UNITS = gpua_pkg::GPUA_CAPACITY;
  localparam int NULL_LINK  = POOL_UNITS;

  // Register indexes beyond the two real registers; the block must ignore them.
  localparam logic [gpua_pkg::GPUA_CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [gpua_pkg::GPUA_CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Generous ceiling for the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 400000;

  // The response path is only the input and output registers, so this wait is plenty.
  localparam int SETTLE_CYCLES = 8;

  // Requests per random traffic phase, and how many held units the drain
  // returns at most.
  localparam int PHASE_ITEMS = 100;
  localparam int DRAIN_LETS  = 150;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  gpua_pkg::gpua_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  gpua_pkg::gpua_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [gpua_pkg::GPUA_CFG_IDX_W-1:0] cfg_index = '0;
  logic [gpua_pkg::GPUA_COUNT_W-1:0]   cfg_data  = '0;

  growing_pool_unit_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the allocator: a LIFO free list threaded
  // through a link table, a fresh-unit pointer inside the newest block, the
  // end of all opened blocks, the two most recent block sizes that drive
  // growth, and the in-use count. The register copies are updated on every
  // configuration transfer.
  // ---------------------------------------------------------------------------
  int unsigned link_of [POOL_UNITS];
  int unsigned list_head    = NULL_LINK;
  int unsigned fresh_next   = 0;
  int unsigned blocks_end   = 0;
  int unsigned newest_size  = 0;
  int unsigned older_size   = 0;
  int unsigned in_use       = 0;
  int unsigned initial_units = gpua_pkg::GPUA_INIT_UNITS_RST;
  bit          geometric    = gpua_pkg::GPUA_GEOMETRIC_RST;

  // Responses the block owes us, oldest first.
  gpua_pkg::gpua_out_t expected_responses [$];

  // Handles the stimulus believes are still handed out; lets draw from here.
  int unsigned held_units [$];

  // Idle behavior of both sides for the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatch_count    = 0;
  int requests_sent     = 0;
  int responses_checked = 0;
  int exhausted_seen    = 0;
  int bad_lets_seen     = 0;
  int blocks_opened     = 0;
  int cycle_count       = 0;

  gpua_pkg::gpua_out_t got_resp;
  gpua_pkg::gpua_out_t want_resp;

  // Size of the block that the next opening would create.
  function automatic int unsigned grown_block_units();
    int unsigned diff;
    if (newest_size == 0) begin
      return (initial_units == 0) ? 1 : initial_units;
    end
    diff = (newest_size >= older_size) ? newest_size - older_size
                                       : older_size - newest_size;
    if (geometric || diff == 0) begin
      return 2 * newest_size;
    end
    return newest_size + diff;
  endfunction

  // Applies one request to the predictor state and returns the response the
  // block must produce for it.
  function automatic gpua_pkg::gpua_out_t pool_response(gpua_pkg::gpua_in_t req);
    gpua_pkg::gpua_out_t resp;
    int unsigned         size;
    int unsigned         granted;
    resp.status = gpua_pkg::ST_OK;
    granted = 0;
    if (req.action == gpua_pkg::ACT_GET) begin
      if (list_head != NULL_LINK) begin
        // Freed units are reused first, most recently freed on top.
        granted   = list_head;
        list_head = link_of[granted];
      end else if (fresh_next < blocks_end) begin
        granted    = fresh_next;
        fresh_next = fresh_next + 1;
      end else begin
        // Current block used up: open the next one right behind it, unless
        // it would run past the end of the pool.
        size = grown_block_units();
        if (blocks_end + size > POOL_UNITS) begin
          resp.status = gpua_pkg::ST_EXHAUSTED;
        end else begin
          older_size  = (newest_size == 0) ? size : newest_size;
          newest_size = size;
          granted     = blocks_end;
          fresh_next  = blocks_end + 1;
          blocks_end  = blocks_end + size;
          blocks_opened++;
        end
      end
      if (resp.status == gpua_pkg::ST_OK && in_use < POOL_UNITS) begin
        in_use++;
      end
    end else begin
      // Only handles below the fresh pointer were ever issued.
      if (req.unit_handle >= fresh_next) begin
        resp.status = gpua_pkg::ST_BAD_HANDLE;
      end else begin
        link_of[req.unit_handle] = list_head;
        list_head = req.unit_handle;
        if (in_use > 0) begin
          in_use--;
        end
      end
    end
    resp.granted_handle = gpua_pkg::GPUA_HANDLE_W'(granted);
    resp.units_in_use   = gpua_pkg::GPUA_COUNT_W'(in_use);
    return resp;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks. Every task starts and ends on a falling edge, which
  // is where all inputs change.
  // ---------------------------------------------------------------------------

  // Sends one request, holding it until the transfer, and records the
  // expected response. in_valid stays high on return so that back-to-back
  // requests need no second assignment in the same time step.
  task automatic send_request(input gpua_pkg::gpua_action_t act,
                              input logic [gpua_pkg::GPUA_HANDLE_W-1:0] handle);
    gpua_pkg::gpua_in_t  req;
    gpua_pkg::gpua_out_t resp;
    req.action      = act;
    req.unit_handle = handle;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    resp = pool_response(req);
    expected_responses.push_back(resp);
    requests_sent++;
    if (act == gpua_pkg::ACT_GET && resp.status == gpua_pkg::ST_OK) begin
      held_units.push_back(resp.granted_handle);
    end
    if (resp.status == gpua_pkg::ST_EXHAUSTED) begin
      exhausted_seen++;
    end
    if (resp.status == gpua_pkg::ST_BAD_HANDLE) begin
      bad_lets_seen++;
    end
    @(negedge clk);
  endtask

  // Drops in_valid and waits until every outstanding response has arrived.
  // The block is idle afterwards, because every request yields a response.
  task automatic pause_sender();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_responses.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // One configuration transfer. Callers make sure the block is idle.
  task automatic write_register(input logic [gpua_pkg::GPUA_CFG_IDX_W-1:0] idx,
                                input logic [gpua_pkg::GPUA_COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gpua_pkg::CFG_INITIAL_UNITS: initial_units = value;
      gpua_pkg::CFG_GEOMETRIC:     geometric = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Takes a random handle out of the held set and lets it back.
  task automatic let_held_unit();
    int slot;
    int unsigned handle;
    slot   = $urandom_range(held_units.size() - 1);
    handle = held_units[slot];
    held_units.delete(slot);
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(handle));
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Short directed sequence on a fresh pool: a zero first-block size, lets of
  // handles that were never issued (including both ends of the handle range
  // and the first unissued handle), the first arithmetic openings, LIFO reuse,
  // a double free, the in-use count held at zero, and register writes that
  // come after the first block is open.
  task automatic test_directed_sequence();
    write_register(gpua_pkg::CFG_INITIAL_UNITS, '0);
    write_register(gpua_pkg::CFG_GEOMETRIC, '0);
    write_register(CFG_SPARE_LO, '1);
    write_register(CFG_SPARE_HI, gpua_pkg::GPUA_COUNT_W'(5));

    send_request(gpua_pkg::ACT_LET, '0);
    send_request(gpua_pkg::ACT_LET, '1);
    // Blocks of 1, then 2 (no difference yet, so it doubles), then 3.
    repeat (4) send_request(gpua_pkg::ACT_GET, '1);
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(4));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(3));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(1));
    repeat (2) send_request(gpua_pkg::ACT_GET, '0);
    // Double free: unit 2 comes back twice and is handed out twice.
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(2));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(2));
    repeat (2) send_request(gpua_pkg::ACT_GET, '0);
    // Return everything, then one more let while the count is already zero.
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(0));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(1));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(2));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(3));
    send_request(gpua_pkg::ACT_LET, gpua_pkg::GPUA_HANDLE_W'(2));
    pause_sender();

    // The first-block size no longer matters; the growth mode does.
    write_register(gpua_pkg::CFG_INITIAL_UNITS, gpua_pkg::GPUA_COUNT_W'(POOL_UNITS));
    write_register(gpua_pkg::CFG_GEOMETRIC, gpua_pkg::GPUA_COUNT_W'(1));
    // Pops the free list only: the double free above has left it looping through units 2 and 3.
    repeat (8) send_request(gpua_pkg::ACT_GET, '0);
    // The units just granted still sit on that looping free list, so none counts as held.
    held_units.delete();
  endtask

  // Reconfigures while idle and selects how both sides idle for the phase.
  task automatic start_phase(input int send_pct, input int recv_pct,
                             input logic [gpua_pkg::GPUA_COUNT_W-1:0] first_units,
                             input logic [gpua_pkg::GPUA_COUNT_W-1:0] growth);
    pause_sender();
    write_register(gpua_pkg::CFG_INITIAL_UNITS, first_units);
    write_register(gpua_pkg::CFG_GEOMETRIC, growth);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Mostly well-formed traffic: gets, and lets of units really handed out.
  // The rest are double frees and lets of arbitrary handles. Now and then
  // the sender holds off until the pipeline is empty.
  task automatic test_random_traffic(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 52 || (pick < 88 && held_units.size() == 0)) begin
        send_request(gpua_pkg::ACT_GET, gpua_pkg::GPUA_HANDLE_W'($urandom));
      end else if (pick < 88) begin
        let_held_unit();
      end else if (pick < 94 && fresh_next > 0) begin
        send_request(gpua_pkg::ACT_LET,
                     gpua_pkg::GPUA_HANDLE_W'($urandom_range(fresh_next - 1)));
      end else begin
        send_request(gpua_pkg::ACT_LET,
                     gpua_pkg::GPUA_HANDLE_W'($urandom_range(POOL_UNITS - 1)));
      end
      if ($urandom_range(149) == 0) begin
        pause_sender();
      end
    end
  endtask

  // Gets until the pool cannot grow, a few more that must fail too, then
  // some lets whose units the following gets must reuse before failing again.
  task automatic test_pool_exhaustion();
    int start_count;
    int guard;
    start_count = exhausted_seen;
    guard = 0;
    while (exhausted_seen == start_count && guard < 2 * POOL_UNITS + 100) begin
      send_request(gpua_pkg::ACT_GET, gpua_pkg::GPUA_HANDLE_W'($urandom));
      guard++;
    end
    repeat (4) send_request(gpua_pkg::ACT_GET, gpua_pkg::GPUA_HANDLE_W'($urandom));
    repeat (6) begin
      if (held_units.size() != 0) begin
        let_held_unit();
      end
    end
    repeat (9) send_request(gpua_pkg::ACT_GET, gpua_pkg::GPUA_HANDLE_W'($urandom));
  endtask

  // Lets a batch of held units back, one more of unit zero, and reuses a
  // few of them.
  task automatic test_pool_drain();
    int lets_left;
    lets_left = DRAIN_LETS;
    while (held_units.size() != 0 && lets_left > 0) begin
      let_held_unit();
      lets_left--;
    end
    send_request(gpua_pkg::ACT_LET, '0);
    repeat (3) send_request(gpua_pkg::ACT_GET, gpua_pkg::GPUA_HANDLE_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls at random per the current phase, changing on the
  // falling edge like every other input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Checks every response transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_resp = out_data;
      if (expected_responses.size() == 0) begin
        $error("response with nothing expected: status %0d handle %0d in use %0d",
               got_resp.status, got_resp.granted_handle, got_resp.units_in_use);
        mismatch_count++;
      end else begin
        want_resp = expected_responses.pop_front();
        responses_checked++;
        if (got_resp.status !== want_resp.status) begin
          $error("status: expected %0d, got %0d", want_resp.status, got_resp.status);
          mismatch_count++;
        end
        if (got_resp.granted_handle !== want_resp.granted_handle) begin
          $error("granted_handle: expected %0d, got %0d",
                 want_resp.granted_handle, got_resp.granted_handle);
          mismatch_count++;
        end
        if (got_resp.units_in_use !== want_resp.units_in_use) begin
          $error("units_in_use: expected %0d, got %0d",
                 want_resp.units_in_use, got_resp.units_in_use);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still expected",
               cycle_count, expected_responses.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Reset is held from the start and released on a falling
  // edge. The directed part runs with no idling; the random phases then walk
  // through sender gaps, receiver stalls and both at once, with the registers
  // moved between phases, extremes included.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_sequence();

    start_phase(0, 0, gpua_pkg::GPUA_COUNT_W'(2047), gpua_pkg::GPUA_COUNT_W'(0));
    test_random_traffic(PHASE_ITEMS);

    start_phase(49, 0, gpua_pkg::GPUA_COUNT_W'(1), gpua_pkg::GPUA_COUNT_W'(1));
    test_random_traffic(PHASE_ITEMS);

    start_phase(17, 17, gpua_pkg::GPUA_COUNT_W'($urandom_range(2047)),
                gpua_pkg::GPUA_COUNT_W'(1));
    test_pool_exhaustion();

    // Bit 0 clear with upper bits set still selects arithmetic growth.
    start_phase(0, 49, gpua_pkg::GPUA_COUNT_W'(0), gpua_pkg::GPUA_COUNT_W'(2046));
    test_random_traffic(PHASE_ITEMS);

    start_phase(17, 17, gpua_pkg::GPUA_COUNT_W'(POOL_UNITS), gpua_pkg::GPUA_COUNT_W'(1));
    test_random_traffic(PHASE_ITEMS);
    test_pool_drain();

    pause_sender();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d responses never arrived", expected_responses.size());
      mismatch_count++;
    end

    $display("Sent %0d get/let transfers and checked %0d responses over %0d cycles.",
             requests_sent, responses_checked, cycle_count);
    $display("Opened %0d blocks up to unit %0d; %0d gets exhausted, %0d lets refused.",
             blocks_opened, blocks_end, exhausted_seen, bad_lets_seen);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
